// File: hw/rtl/dda_line_rasterizer_assert.svh
// Assertion macros for the DDA line rasterizer.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef DDA_LINE_RASTERIZER_ASSERT_SVH
`define DDA_LINE_RASTERIZER_ASSERT_SVH

// Condition holds at every clock edge outside reset
`define DLR_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent at one edge implies consequent at the next edge
`define DLR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/dlr_pkg.sv
// Shared constants and types for the DDA line rasterizer.
// No dependencies.
`timescale 1ns / 1ps

package dlr_pkg;

    // Coordinate and span widths
    localparam int COORD_BITS = 12;
    localparam int SPAN_BITS  = COORD_BITS + 1;
    localparam int CLIP_BITS  = 11;
    // Width that holds both a signed coordinate and a zero-extended clip bound
    localparam int CMP_BITS   = (COORD_BITS > CLIP_BITS) ? COORD_BITS + 1 : CLIP_BITS + 1;

    // Stream payload widths, rounded up to whole bytes
    localparam int IN_DATA_BITS  = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

    // Clip window reset values
    localparam logic [CLIP_BITS-1:0] CLIP_WIDTH_RESET  = CLIP_BITS'(771);
    localparam logic [CLIP_BITS-1:0] CLIP_HEIGHT_RESET = CLIP_BITS'(491);

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_HEIGHT = CFG_INDEX_BITS'(1);

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [SPAN_BITS-1:0]         span_t;
    typedef logic [CLIP_BITS-1:0]         clip_t;

endpackage

// File: hw/rtl/dda_line_rasterizer.sv
// An accepted step request passes the input stage and then the output register.
// Throughput: one request per cycle; load requests give no pixel and never wait on
// the output. A step that waits on a full output register holds s_tready low, and
// s_tready follows m_tready in that same cycle.
// The loop that sets the rate is the registered update of the error accumulator.
// Reset (rst_n low, asynchronous) drops any line, empties both stages and
// restores the clip window to 771 x 491.
// Top level of the DDA line rasterizer; depends on dlr_pkg and the assertion header.
`timescale 1ns / 1ps
`include "dda_line_rasterizer_assert.svh"

module dda_line_rasterizer
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Request stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // s_tdata: x_start, y_start, x_end, y_end (lowest bits first)
    input  logic [dlr_pkg::IN_DATA_BITS-1:0]     s_tdata,
    // s_tuser: command
    input  logic                                 s_tuser,
    // Pixel stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // m_tdata: pixel_x, pixel_y (lowest bits first)
    output logic [dlr_pkg::OUT_DATA_BITS-1:0]    m_tdata,
    // m_tuser: visible
    output logic                                 m_tuser,
    output logic                                 m_tlast,
    // Configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dlr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [dlr_pkg::CLIP_BITS-1:0]        cfg_data
);

    localparam int CB = dlr_pkg::COORD_BITS;
    localparam int SB = dlr_pkg::SPAN_BITS;
    localparam int MB = dlr_pkg::CMP_BITS;

    // Clip window
    dlr_pkg::clip_t clip_width_reg;
    dlr_pkg::clip_t clip_height_reg;

    // Input stage
    logic           in_valid_reg;
    logic           in_cmd_reg;
    dlr_pkg::coord_t in_xs_reg;
    dlr_pkg::coord_t in_ys_reg;
    dlr_pkg::coord_t in_xe_reg;
    dlr_pkg::coord_t in_ye_reg;

    // Line state
    logic            line_active_reg, line_active_next;
    logic            x_major_reg,     x_major_next;
    dlr_pkg::coord_t major_pos_reg,   major_pos_next;
    dlr_pkg::coord_t major_final_reg, major_final_next;
    dlr_pkg::coord_t minor_pos_reg,   minor_pos_next;
    dlr_pkg::span_t  err_reg,         err_next;
    dlr_pkg::span_t  major_span_reg,  major_span_next;
    dlr_pkg::span_t  minor_span_reg,  minor_span_next;
    logic            minor_dir_reg,   minor_dir_next;

    // Output stage
    logic            out_valid_reg,   out_valid_next;
    dlr_pkg::coord_t out_x_reg;
    dlr_pkg::coord_t out_y_reg;
    logic            out_vis_reg;
    logic            out_last_reg;

    // Handshake control
    logic step_emit;
    logic out_free;
    logic proc_fire;

    // Load path
    logic signed [SB-1:0] dx_s, dy_s;
    dlr_pkg::span_t       dx_abs, dy_abs;
    logic                 load_x_major;
    logic                 load_swap;
    logic signed [SB-1:0] minor_diff;

    // Step path
    dlr_pkg::coord_t      px, py;
    logic signed [MB-1:0] px_ext, py_ext, cw_ext, ch_ext;
    logic                 pix_vis;
    logic                 pix_last;
    logic [SB:0]          err_up;

    assign cfg_ready = 1'b1;

    // Write clip registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_width_reg  <= dlr_pkg::CLIP_WIDTH_RESET;
            clip_height_reg <= dlr_pkg::CLIP_HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == dlr_pkg::CFG_CLIP_WIDTH)
                clip_width_reg <= cfg_data;
            else if (cfg_index == dlr_pkg::CFG_CLIP_HEIGHT)
                clip_height_reg <= cfg_data;
        end
    end

    // Advance the input stage when it is empty or its request is processed
    assign step_emit = in_valid_reg && (in_cmd_reg == dlr_pkg::CMD_STEP) && line_active_reg;
    assign out_free  = !out_valid_reg || m_tready;
    assign proc_fire = in_valid_reg && (!step_emit || out_free);
    assign s_tready  = !in_valid_reg || proc_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cmd_reg <= s_tuser;
            in_xs_reg  <= s_tdata[CB-1:0];
            in_ys_reg  <= s_tdata[2*CB-1:CB];
            in_xe_reg  <= s_tdata[3*CB-1:2*CB];
            in_ye_reg  <= s_tdata[4*CB-1:3*CB];
        end
    end

    // Spans and axis choice for a load
    always_comb
    begin
        dx_s   = SB'(in_xe_reg) - SB'(in_xs_reg);
        dy_s   = SB'(in_ye_reg) - SB'(in_ys_reg);
        dx_abs = dx_s[SB-1] ? dlr_pkg::span_t'(-dx_s) : dlr_pkg::span_t'(dx_s);
        dy_abs = dy_s[SB-1] ? dlr_pkg::span_t'(-dy_s) : dlr_pkg::span_t'(dy_s);
        load_x_major = dx_abs > dy_abs;
        load_swap    = load_x_major ? dx_s[SB-1] : dy_s[SB-1];
        minor_diff   = load_x_major ? dy_s : dx_s;
    end

    // Current pixel, its visibility and whether it ends the run
    always_comb
    begin
        px       = x_major_reg ? major_pos_reg : minor_pos_reg;
        py       = x_major_reg ? minor_pos_reg : major_pos_reg;
        px_ext   = MB'(px);
        py_ext   = MB'(py);
        cw_ext   = $signed(MB'(clip_width_reg));
        ch_ext   = $signed(MB'(clip_height_reg));
        pix_vis  = (px_ext > 0) && (py_ext > 0) && (px_ext < cw_ext) && (py_ext < ch_ext);
        pix_last = major_pos_reg >= major_final_reg;
        err_up   = {1'b0, err_reg} + {1'b0, minor_span_reg};
    end

    // Next line state
    always_comb
    begin
        line_active_next = line_active_reg;
        x_major_next     = x_major_reg;
        major_pos_next   = major_pos_reg;
        major_final_next = major_final_reg;
        minor_pos_next   = minor_pos_reg;
        err_next         = err_reg;
        major_span_next  = major_span_reg;
        minor_span_next  = minor_span_reg;
        minor_dir_next   = minor_dir_reg;
        if (proc_fire)
        begin
            if (in_cmd_reg == dlr_pkg::CMD_LOAD)
            begin
                // Latch the new line, ordered so the major coordinate rises
                line_active_next = 1'b1;
                x_major_next     = load_x_major;
                err_next         = '0;
                major_span_next  = load_x_major ? dx_abs : dy_abs;
                minor_span_next  = load_x_major ? dy_abs : dx_abs;
                minor_dir_next   = load_swap ? (minor_diff > 0) : minor_diff[SB-1];
                if (load_x_major)
                begin
                    major_pos_next   = load_swap ? in_xe_reg : in_xs_reg;
                    major_final_next = load_swap ? in_xs_reg : in_xe_reg;
                    minor_pos_next   = load_swap ? in_ye_reg : in_ys_reg;
                end
                else
                begin
                    major_pos_next   = load_swap ? in_ye_reg : in_ys_reg;
                    major_final_next = load_swap ? in_ys_reg : in_ye_reg;
                    minor_pos_next   = load_swap ? in_xe_reg : in_xs_reg;
                end
            end
            else if (line_active_reg)
            begin
                if (pix_last)
                    line_active_next = 1'b0;
                else
                begin
                    // Advance one step along the major axis
                    major_pos_next = major_pos_reg + dlr_pkg::coord_t'(1);
                    if (minor_dir_reg)
                    begin
                        if (err_reg >= minor_span_reg)
                            err_next = err_reg - minor_span_reg;
                        else
                        begin
                            err_next       = err_reg + major_span_reg - minor_span_reg;
                            minor_pos_next = minor_pos_reg - dlr_pkg::coord_t'(1);
                        end
                    end
                    else
                    begin
                        if (err_up >= {1'b0, major_span_reg})
                        begin
                            err_next       = SB'(err_up - {1'b0, major_span_reg});
                            minor_pos_next = minor_pos_reg + dlr_pkg::coord_t'(1);
                        end
                        else
                            err_next = SB'(err_up);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_active_reg <= 1'b0;
            x_major_reg     <= 1'b0;
            major_pos_reg   <= '0;
            major_final_reg <= '0;
            minor_pos_reg   <= '0;
            err_reg         <= '0;
            major_span_reg  <= '0;
            minor_span_reg  <= '0;
            minor_dir_reg   <= 1'b0;
        end
        else
        begin
            line_active_reg <= line_active_next;
            x_major_reg     <= x_major_next;
            major_pos_reg   <= major_pos_next;
            major_final_reg <= major_final_next;
            minor_pos_reg   <= minor_pos_next;
            err_reg         <= err_next;
            major_span_reg  <= major_span_next;
            minor_span_reg  <= minor_span_next;
            minor_dir_reg   <= minor_dir_next;
        end
    end

    // Output register: load on an emitted step, drop once taken
    always_comb
    begin
        if (step_emit && proc_fire)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step_emit && proc_fire)
        begin
            out_x_reg    <= px;
            out_y_reg    <= py;
            out_vis_reg  <= pix_vis;
            out_last_reg <= pix_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = dlr_pkg::OUT_DATA_BITS'({out_y_reg, out_x_reg});
    assign m_tuser  = out_vis_reg;
    assign m_tlast  = out_last_reg;

    // Checks on the line state and the output stage
    `DLR_ASSERT_ALWAYS(a_err_range, (err_reg < major_span_reg) || (err_reg == '0),
        "error accumulator out of range")
    `DLR_ASSERT_ALWAYS(a_span_order, minor_span_reg <= major_span_reg,
        "minor span exceeds major span")
    `DLR_ASSERT_ALWAYS(a_major_bound, !line_active_reg || (major_pos_reg <= major_final_reg),
        "major position passed end")
    `DLR_ASSERT_NEXT(a_emit_valid, step_emit && proc_fire, m_tvalid, "emitted step gave no pixel")

endmodule

// File: tb/dda_line_rasterizer_test.sv
// Self-checking testbench for dda_line_rasterizer: drives load and step requests,
// predicts every pixel in a scoreboard class and compares the pixel stream.
// Depends on dlr_pkg and the dda_line_rasterizer RTL.
`timescale 1ns / 1ps

module dda_line_rasterizer_test;
    import dlr_pkg::*;

    localparam int IDLE_LIMIT    = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 1750;
    localparam int PHASES        = 6;
    localparam int COORD_MAX     = 2 ** (COORD_BITS - 1) - 1;
    localparam int COORD_MIN     = -(2 ** (COORD_BITS - 1));
    // Register index that maps to no register
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = CFG_INDEX_BITS'(3);

    typedef struct packed
    {
        coord_t x;
        coord_t y;
        logic   visible;
        logic   last;
    } pixel_t;

    // Tracks the line walker and holds the pixels still owed by the block
    class raster_tracker;
        clip_t                     clip_w;
        clip_t                     clip_h;
        bit                        active;
        bit                        x_major;
        bit                        minor_falls;
        coord_t                    major_pos;
        coord_t                    major_end;
        coord_t                    minor_pos;
        span_t                     major_span;
        span_t                     minor_span;
        logic signed [SPAN_BITS:0] err_acc;
        pixel_t                    owed_pixels[$];
        int                        errors;

        function new();
            clip_w      = CLIP_WIDTH_RESET;
            clip_h      = CLIP_HEIGHT_RESET;
            active      = 1'b0;
            x_major     = 1'b0;
            minor_falls = 1'b0;
            major_pos   = '0;
            major_end   = '0;
            minor_pos   = '0;
            major_span  = '0;
            minor_span  = '0;
            err_acc     = '0;
            errors      = 0;
        endfunction

        function void set_clip(logic [CFG_INDEX_BITS-1:0] index, clip_t value);
            if (index == CFG_CLIP_WIDTH)
                clip_w = value;
            else if (index == CFG_CLIP_HEIGHT)
                clip_h = value;
        endfunction

        // Apply one accepted request; a step on an active line owes one pixel
        function void take_request(logic cmd, coord_t xa, coord_t ya, coord_t xb, coord_t yb);
            int     dx;
            int     dy;
            int     ma;
            int     mb;
            int     na;
            int     nb;
            int     swap;
            coord_t px;
            coord_t py;
            pixel_t pix;
            if (cmd == CMD_LOAD)
            begin
                dx = int'(xb) - int'(xa);
                dy = int'(yb) - int'(ya);
                if (dx < 0)
                    dx = -dx;
                if (dy < 0)
                    dy = -dy;
                // Ties go to the y axis
                x_major = dx > dy;
                if (x_major)
                begin
                    ma = xa; mb = xb; na = ya; nb = yb;
                end
                else
                begin
                    ma = ya; mb = yb; na = xa; nb = xb;
                end
                // Order endpoints so the major coordinate rises
                if (ma > mb)
                begin
                    swap = ma; ma = mb; mb = swap;
                    swap = na; na = nb; nb = swap;
                end
                major_pos   = coord_t'(ma);
                major_end   = coord_t'(mb);
                minor_pos   = coord_t'(na);
                major_span  = span_t'(mb - ma);
                minor_falls = nb < na;
                minor_span  = span_t'(minor_falls ? na - nb : nb - na);
                err_acc     = '0;
                active      = 1'b1;
            end
            else if (active)
            begin
                px = x_major ? major_pos : minor_pos;
                py = x_major ? minor_pos : major_pos;
                pix.x       = px;
                pix.y       = py;
                pix.visible = int'(px) > 0 && int'(py) > 0 &&
                              int'(px) < int'(clip_w) && int'(py) < int'(clip_h);
                pix.last    = major_pos >= major_end;
                owed_pixels.push_back(pix);
                if (pix.last)
                    active = 1'b0;
                else
                begin
                    // Advance the major axis and carry the remainder into the minor axis
                    major_pos = major_pos + coord_t'(1);
                    if (minor_falls)
                    begin
                        err_acc = err_acc - $signed({1'b0, minor_span});
                        if (err_acc < 0)
                        begin
                            err_acc   = err_acc + $signed({1'b0, major_span});
                            minor_pos = minor_pos - coord_t'(1);
                        end
                    end
                    else
                    begin
                        err_acc = err_acc + $signed({1'b0, minor_span});
                        if (err_acc >= $signed({1'b0, major_span}))
                        begin
                            err_acc   = err_acc - $signed({1'b0, major_span});
                            minor_pos = minor_pos + coord_t'(1);
                        end
                    end
                end
            end
        endfunction

        // Compare one delivered pixel with the oldest owed pixel
        function void match_pixel(coord_t x, coord_t y, logic vis, logic last);
            pixel_t want;
            if (owed_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel x=%0d y=%0d visible=%0b last=%0b",
                         $time, x, y, vis, last);
                errors++;
                return;
            end
            want = owed_pixels.pop_front();
            if (want.x !== x)
            begin
                $display("%0t: pixel_x expected %0d actual %0d", $time, $signed(want.x), x);
                errors++;
            end
            if (want.y !== y)
            begin
                $display("%0t: pixel_y expected %0d actual %0d", $time, $signed(want.y), y);
                errors++;
            end
            if (want.visible !== vis)
            begin
                $display("%0t: visible expected %0b actual %0b", $time, want.visible, vis);
                errors++;
            end
            if (want.last !== last)
            begin
                $display("%0t: last expected %0b actual %0b", $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [IN_DATA_BITS-1:0]   s_tdata   = '0;
    logic                      s_tuser   = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [OUT_DATA_BITS-1:0]  m_tdata;
    logic                      m_tuser;
    logic                      m_tlast;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    clip_t                     cfg_data  = '0;

    raster_tracker tracker = new();

    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    bit hold_request  = 1'b0;
    int quiet_cycles  = 0;
    int sent          = 0;

    dda_line_rasterizer i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Stall the pixel side at random; hold off for a long stretch on request
    always @(posedge clk)
    begin
        int hold_left;
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Observe all three channels and watch for a stuck block
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles = 0;
        else
        begin
            if (m_tvalid && m_tready)
                tracker.match_pixel(coord_t'(m_tdata[COORD_BITS-1:0]),
                                    coord_t'(m_tdata[2*COORD_BITS-1:COORD_BITS]),
                                    m_tuser, m_tlast);
            if (s_tvalid && s_tready)
                tracker.take_request(s_tuser,
                                     coord_t'(s_tdata[COORD_BITS-1:0]),
                                     coord_t'(s_tdata[2*COORD_BITS-1:COORD_BITS]),
                                     coord_t'(s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
                                     coord_t'(s_tdata[4*COORD_BITS-1:3*COORD_BITS]));
            if (cfg_valid && cfg_ready)
                tracker.set_clip(cfg_index, cfg_data);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("dda_line_rasterizer regression: fail");
                $finish;
            end
        end
    end

    function automatic coord_t clamp_coord(int v);
        if (v < COORD_MIN)
            v = COORD_MIN;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return coord_t'(v);
    endfunction

    // Pick a coordinate: full range, near zero, near the clip bound or on screen
    function automatic coord_t pick_coord(int bound);
        int v;
        case ($urandom_range(0, 3))
            0:       v = int'($urandom_range(0, 4095)) + COORD_MIN;
            1:       v = int'($urandom_range(0, 8)) - 4;
            2:       v = bound + int'($urandom_range(0, 8)) - 4;
            default: v = int'($urandom_range(0, 2047));
        endcase
        return clamp_coord(v);
    endfunction

    task automatic write_config(logic [CFG_INDEX_BITS-1:0] index, clip_t value, bit more);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (!more)
            cfg_valid <= 1'b0;
    endtask

    task automatic send_request(logic cmd, coord_t xa, coord_t ya, coord_t xb, coord_t yb);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= IN_DATA_BITS'({yb, xb, ya, xa});
        do
            @(posedge clk);
        while (!s_tready);
        sent++;
    endtask

    // Step request; the endpoint fields carry noise
    task automatic send_step();
        send_request(CMD_STEP, coord_t'($urandom()), coord_t'($urandom()),
                     coord_t'($urandom()), coord_t'($urandom()));
    endtask

    // Drop valid, wait for every owed pixel, then let the pipeline drain
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.owed_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly short lines walked to the end, some long lines cut short, some noise
    task automatic run_phase(int items);
        int     stop;
        int     span;
        int     dx;
        int     dy;
        int     steps;
        int     kind;
        coord_t xa;
        coord_t ya;
        coord_t xb;
        coord_t yb;
        stop = sent + items;
        while (sent < stop)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 72)
            begin
                xa   = pick_coord(int'(tracker.clip_w));
                ya   = pick_coord(int'(tracker.clip_h));
                span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 4);
                xb   = clamp_coord(int'(xa) + int'($urandom_range(0, 2 * span)) - span);
                yb   = clamp_coord(int'(ya) + int'($urandom_range(0, 2 * span)) - span);
                dx   = int'(xb) - int'(xa);
                dy   = int'(yb) - int'(ya);
                if (dx < 0)
                    dx = -dx;
                if (dy < 0)
                    dy = -dy;
                steps = ((dx > dy) ? dx : dy) + 1;
                // Sometimes step past the end, sometimes abandon the line early
                case ($urandom_range(0, 9))
                    0:       steps = steps + $urandom_range(1, 3);
                    1:       steps = $urandom_range(0, steps - 1);
                    default: ;
                endcase
                send_request(CMD_LOAD, xa, ya, xb, yb);
                repeat (steps) send_step();
            end
            else if (kind < 84)
            begin
                send_request(CMD_LOAD, coord_t'($urandom()), coord_t'($urandom()),
                             coord_t'($urandom()), coord_t'($urandom()));
                repeat ($urandom_range(2, 30)) send_step();
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    send_request($urandom_range(0, 1) ? CMD_STEP : CMD_LOAD,
                                 coord_t'($urandom()), coord_t'($urandom()),
                                 coord_t'($urandom()), coord_t'($urandom()));
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: step with no line, single pixel, falling minor, tie at the clip edge
        send_step();
        send_request(CMD_LOAD, coord_t'(5), coord_t'(5), coord_t'(5), coord_t'(5));
        send_step();
        send_step();
        send_request(CMD_LOAD, coord_t'(0), coord_t'(0), coord_t'(3), coord_t'(-2));
        repeat (4) send_step();
        send_request(CMD_LOAD, coord_t'(770), coord_t'(490), coord_t'(772), coord_t'(488));
        repeat (3) send_step();
        // Extreme endpoints, the two long diagonals replaced while still running
        send_request(CMD_LOAD, coord_t'(COORD_MIN), coord_t'(COORD_MAX),
                     coord_t'(COORD_MAX), coord_t'(COORD_MIN));
        repeat (2) send_step();
        send_request(CMD_LOAD, coord_t'(COORD_MAX), coord_t'(COORD_MIN),
                     coord_t'(COORD_MIN), coord_t'(COORD_MAX));
        repeat (2) send_step();
        send_request(CMD_LOAD, coord_t'(COORD_MAX), coord_t'(COORD_MAX),
                     coord_t'(COORD_MAX), coord_t'(COORD_MAX));
        send_step();
        settle();

        // Random phases, each with its own clip window; each pair of phases shares an idle pattern
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase / 2)
                0:
                begin
                    tx_idle_pct = 36;
                    rx_idle_pct = 46;
                end
                1:
                begin
                    tx_idle_pct = 46;
                    rx_idle_pct = 36;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            case (phase)
                0:
                begin
                    write_config(CFG_SPARE, clip_t'($urandom()), 1'b1);
                    write_config(CFG_CLIP_WIDTH, clip_t'(2047), 1'b1);
                    write_config(CFG_CLIP_HEIGHT, clip_t'(2047), 1'b0);
                end
                1:
                begin
                    write_config(CFG_CLIP_WIDTH, clip_t'(0), 1'b1);
                    write_config(CFG_CLIP_HEIGHT, clip_t'(0), 1'b0);
                end
                2:
                begin
                    write_config(CFG_CLIP_WIDTH, clip_t'($urandom()), 1'b1);
                    write_config(CFG_CLIP_HEIGHT, clip_t'($urandom()), 1'b0);
                end
                3:
                begin
                    write_config(CFG_CLIP_WIDTH, clip_t'(2047), 1'b1);
                    write_config(CFG_CLIP_HEIGHT, clip_t'(0), 1'b0);
                end
                4:
                begin
                    write_config(CFG_CLIP_WIDTH, clip_t'($urandom_range(1, 64)), 1'b1);
                    write_config(CFG_CLIP_HEIGHT, clip_t'($urandom_range(1, 64)), 1'b0);
                    // Hold off the pixel side while requests keep coming
                    hold_request = 1'b1;
                end
                default:
                begin
                    write_config(CFG_CLIP_WIDTH, clip_t'(0), 1'b1);
                    write_config(CFG_CLIP_HEIGHT, clip_t'(2047), 1'b0);
                end
            endcase
            run_phase(RANDOM_ITEMS / PHASES);
            settle();
        end

        if (tracker.errors == 0)
            $display("dda_line_rasterizer regression: pass");
        else
            $display("dda_line_rasterizer regression: fail");
        $finish;
    end

endmodule
